// ===== hw/rtl/mss_pkg.sv =====
// Shared types, constants and the segment decode table for the
// multiplexed seven-segment scanner. No dependencies.
`timescale 1ns / 1ps

package mss_pkg;

  localparam int VALUE_W    = 14;
  localparam int SEG_W      = 7;
  localparam int EN_W       = 4;
  localparam int DWELL_W    = 16;
  localparam int BCD_W      = 4;
  localparam int DEC_DIGITS = 5;  // decimal digits a 14-bit value can have

  localparam logic [DWELL_W-1:0] DWELL_RESET = 16'd5000;
  localparam logic [DWELL_W-1:0] DWELL_MIN   = 16'd2;

  // reciprocal multipliers for exact division of 14-bit values
  localparam logic [15:0] DIV10_K    = 16'd52429;  // shift 19
  localparam logic [12:0] DIV100_K   = 13'd5243;   // shift 19
  localparam logic [13:0] DIV1000_K  = 14'd8389;   // shift 23
  localparam logic [13:0] TEN_THOUSAND = 14'd10000;

  typedef enum logic [0:0] {
    CMD_TICK = 1'b0,
    CMD_LOAD = 1'b1
  } cmd_e;

  typedef enum logic [0:0] {
    REG_COMMON_HIGH = 1'b0,
    REG_DWELL_TICKS = 1'b1
  } reg_e;

  typedef logic [BCD_W-1:0] bcd_t;

  typedef struct packed {
    cmd_e               command;
    logic [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [SEG_W-1:0] segments;
    logic [EN_W-1:0]  digit_enable;
  } out_item_t;

  typedef struct packed {
    reg_e               index;
    logic [DWELL_W-1:0] wdata;
  } cfg_item_t;

  // bit 6 = a .. bit 0 = g
  function automatic logic [SEG_W-1:0] seg_of(bcd_t d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0:    s = 7'b1111110;
      4'd1:    s = 7'b0110000;
      4'd2:    s = 7'b1101101;
      4'd3:    s = 7'b1111001;
      4'd4:    s = 7'b0110011;
      4'd5:    s = 7'b1011011;
      4'd6:    s = 7'b1011111;
      4'd7:    s = 7'b1110000;
      4'd8:    s = 7'b1111111;
      4'd9:    s = 7'b1111011;
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

// ===== hw/rtl/mss_chan_if.sv =====
// Valid/ready channel carrying one item of type T.
// Payload types come from mss_pkg.
`timescale 1ns / 1ps

interface mss_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/mss_split.sv =====
// Two-stage binary to decimal split of the loaded value.
// Uses mss_pkg for widths and reciprocal constants.
`timescale 1ns / 1ps

module mss_split import mss_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [VALUE_W-1:0] value_i,
  output bcd_t               digits_o [DEC_DIGITS]
);

  logic [29:0] p10;
  logic [26:0] p100;
  logic [27:0] p1000;

  logic [VALUE_W-1:0] value_q;
  logic [10:0]        q10_q;
  logic [7:0]         q100_q;
  logic [4:0]         q1000_q;
  logic               q10k_q;
  bcd_t               digits_d [DEC_DIGITS];
  bcd_t               digits_q [DEC_DIGITS];

  assign p10   = 30'(value_i) * 30'(DIV10_K);
  assign p100  = 27'(value_i) * 27'(DIV100_K);
  assign p1000 = 28'(value_i) * 28'(DIV1000_K);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      value_q <= value_i;
      q10_q   <= p10[29:19];
      q100_q  <= p100[26:19];
      q1000_q <= p1000[27:23];
      q10k_q  <= (value_i >= TEN_THOUSAND);
    end
  end

  // digit k = floor(v / 10^k) - 10 * floor(v / 10^(k+1))
  always_comb begin
    digits_d[0] = BCD_W'(value_q - 14'(q10_q) * 14'd10);
    digits_d[1] = BCD_W'(q10_q - 11'(q100_q) * 11'd10);
    digits_d[2] = BCD_W'(q100_q - 8'(q1000_q) * 8'd10);
    digits_d[3] = BCD_W'(q1000_q - 5'(q10k_q) * 5'd10);
    digits_d[4] = BCD_W'(q10k_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      digits_q <= digits_d;
    end
  end

  assign digits_o = digits_q;

endmodule

// ===== hw/rtl/mss_decode.sv =====
// Segment and digit-enable decode for one scan slot, with blanking and
// polarity. Uses mss_pkg for the segment table and the result item type.
`timescale 1ns / 1ps

module mss_decode import mss_pkg::*; #(
  parameter int POS_W = 2
) (
  input  bcd_t             digit_i,
  input  logic [POS_W-1:0] pos_i,
  input  logic             blank_i,
  input  logic             common_high_i,
  output out_item_t        item_o
);

  logic [SEG_W-1:0] seg;
  logic [EN_W-1:0]  en;

  always_comb begin
    seg = '0;
    en  = '0;
    if (!blank_i) begin
      seg = seg_of(digit_i);
      if (32'(pos_i) < EN_W) begin
        en = EN_W'(1) << pos_i;
      end
    end
    if (common_high_i) begin
      seg = ~seg;
    end
    item_o.segments     = seg;
    item_o.digit_enable = en;
  end

endmodule

// ===== hw/rtl/multiplexed_seven_segment_scanner_unit.sv =====
// Multiplexed seven-segment scanner. Takes one item per clock: a tick
// advances the dwell counter and the scan, a load stores a value as decimal
// digits. Each item gives one result through the input stage with the
// reciprocal dividers, decimal digit stage and output register; the pipeline
// stalls as a whole only while the output item is not taken.
// Depends on mss_pkg, mss_chan_if, mss_split and mss_decode.
`timescale 1ns / 1ps

module multiplexed_seven_segment_scanner_unit import mss_pkg::*; #(
  parameter int DIGIT_COUNT = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mss_chan_if.sink   in_i,
  mss_chan_if.source out_o,
  mss_chan_if.sink   cfg_i
);

  localparam int POS_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(DIGIT_COUNT - 1);

  logic               common_high_q;
  logic [DWELL_W-1:0] dwell_ticks_q;
  logic [DWELL_W-1:0] dwell_len;

  logic [POS_W-1:0]   scan_q, scan_d;
  logic [DWELL_W-1:0] dwell_q, dwell_d;
  logic [DWELL_W:0]   dwell_inc;
  logic               wrap;
  logic               blank_now;

  logic adv, acc, is_tick, is_load;

  logic             v1_q, v2_q, out_valid_q;
  logic             ld1_q, ld2_q, blank1_q, blank2_q;
  logic [POS_W-1:0] pos1_q, pos2_q;
  out_item_t        out_data_q;
  out_item_t        dec_item;

  bcd_t split_digits [DEC_DIGITS];
  bcd_t next_digits  [DIGIT_COUNT];
  bcd_t digits_q     [DIGIT_COUNT];
  bcd_t cur_digit;

  // configuration
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      common_high_q <= 1'b0;
      dwell_ticks_q <= DWELL_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        REG_COMMON_HIGH: common_high_q <= cfg_i.data.wdata[0];
        REG_DWELL_TICKS: dwell_ticks_q <= cfg_i.data.wdata;
        default: ;
      endcase
    end
  end

  assign dwell_len = (dwell_ticks_q < DWELL_MIN) ? DWELL_MIN : dwell_ticks_q;

  // handshake
  assign adv         = !out_valid_q || out_o.ready;
  assign in_i.ready  = adv;
  assign acc         = in_i.valid && adv;
  assign is_tick     = acc && (in_i.data.command == CMD_TICK);
  assign is_load     = acc && (in_i.data.command == CMD_LOAD);

  // scan state
  assign blank_now = dwell_q >= (dwell_len - DWELL_W'(1));
  assign dwell_inc = {1'b0, dwell_q} + (DWELL_W + 1)'(1);
  assign wrap      = dwell_inc >= {1'b0, dwell_len};

  always_comb begin
    scan_d  = scan_q;
    dwell_d = dwell_q;
    if (is_tick) begin
      if (wrap) begin
        dwell_d = '0;
        scan_d  = (scan_q == POS_LAST) ? '0 : scan_q + POS_W'(1);
      end else begin
        dwell_d = dwell_inc[DWELL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q  <= '0;
      dwell_q <= '0;
    end else begin
      scan_q  <= scan_d;
      dwell_q <= dwell_d;
    end
  end

  // pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= acc;
      v2_q        <= v1_q;
      out_valid_q <= v2_q;
    end
  end

  // pipeline sideband
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ld1_q    <= is_load;
      blank1_q <= blank_now;
      pos1_q   <= scan_q;
      ld2_q    <= ld1_q;
      blank2_q <= blank1_q;
      pos2_q   <= pos1_q;
    end
  end

  mss_split u_split (
    .clk_i    (clk_i),
    .en_i     (adv),
    .value_i  (in_i.data.value),
    .digits_o (split_digits)
  );

  for (genvar i = 0; i < DIGIT_COUNT; i++) begin : g_digit
    if (i < DEC_DIGITS) begin : g_dec
      assign next_digits[i] = split_digits[i];
    end else begin : g_zero
      assign next_digits[i] = '0;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        digits_q[i] <= '0;
      end else if (adv && v2_q && ld2_q) begin
        digits_q[i] <= next_digits[i];
      end
    end
  end

  assign cur_digit = ld2_q ? next_digits[pos2_q] : digits_q[pos2_q];

  mss_decode #(
    .POS_W (POS_W)
  ) u_decode (
    .digit_i       (cur_digit),
    .pos_i         (pos2_q),
    .blank_i       (blank2_q),
    .common_high_i (common_high_q),
    .item_o        (dec_item)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= dec_item;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // checks
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_q <= POS_LAST)
    else $error("scan position out of range");

  a_tick_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_tick && !wrap) |=> (dwell_q == $past(dwell_q) + DWELL_W'(1)))
    else $error("dwell count did not advance on tick");

  a_load_holds_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_load |=> ($stable(scan_q) && $stable(dwell_q)))
    else $error("load moved the scan state");

  a_blank_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && v2_q && blank2_q) |=> (out_data_q.digit_enable == '0))
    else $error("blank item drives a digit enable");

endmodule
